[sv/bnc_pkg.sv]
// ----------------------------------------------------------------------------
// Bracket nesting checker package
// Item types, result codes and shared constants for the checker core.
// ----------------------------------------------------------------------------
`default_nettype none

package bnc_pkg;

  // Fixed field widths
  localparam int unsigned IdxW   = 16;
  localparam int unsigned DepthW = 6;

  // Token classes
  localparam logic [2:0] TC_PLAIN  = 3'd0;
  localparam logic [2:0] TC_UNUSED = 3'd7;

  // Input commands
  localparam logic CMD_TOKEN = 1'b0;
  localparam logic CMD_END   = 1'b1;

  // Bracket kinds
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Result events
  typedef enum logic [2:0] {
    EV_PLAIN    = 3'd0,
    EV_OPEN     = 3'd1,
    EV_MATCH    = 3'd2,
    EV_MISMATCH = 3'd3,
    EV_DANGLE   = 3'd4,
    EV_BALANCED = 3'd5,
    EV_OVERFLOW = 3'd6
  } event_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN_RD,
    ST_DRAIN_EMIT
  } state_e;

  typedef struct packed {
    logic            cmd;
    logic [2:0]      token_class;
    logic [IdxW-1:0] token_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [1:0]        bracket_kind;
    logic [IdxW-1:0]   open_index;
    logic [IdxW-1:0]   close_index;
    logic [DepthW-1:0] depth;
    logic              all_ok;
    logic              last;
  } out_item_t;

  // One stack entry: opener kind and its token index
  typedef struct packed {
    logic [1:0]      kind;
    logic [IdxW-1:0] index;
  } stk_entry_t;

endpackage

`default_nettype wire

[sv/bnc_stack_mem.sv]
// ----------------------------------------------------------------------------
// Bracket stack memory
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bnc_stack_mem #(
  parameter int unsigned Depth = 32
) (
  input  wire                                clk_i,
  input  wire                                wr_en_i,
  input  wire  [$clog2(Depth)-1:0]           wr_addr_i,
  input  wire  bnc_pkg::stk_entry_t          wr_data_i,
  input  wire  [$clog2(Depth)-1:0]           rd_addr_i,
  output bnc_pkg::stk_entry_t                rd_data_o
);
  import bnc_pkg::*;

  stk_entry_t mem_q [Depth];
  stk_entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[sv/bracket_nesting_checker_core.sv]
// A token item's result is registered: the accepting edge reads the stack top from
//   RAM, the item waits in the execute state until the output register is free,
//   then its result is loaded. No new item is taken until the sequencer is idle.
// End of stream with N open brackets gives N results, the first from the execute
//   state and each further one from a drain read and a drain emit state (one RAM read per entry).
// Reset clears depth, sequencer and output valid and sets the ok flag; the stack RAM is not reset.
// ----------------------------------------------------------------------------
// Bracket nesting checker core
// Matches three bracket kinds with a RAM-held stack, reports dangling openers.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_nesting_checker_core #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire bnc_pkg::in_item_t in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output bnc_pkg::out_item_t  out_item_o
);
  import bnc_pkg::*;

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);

  state_e          state_q, state_d;
  logic [SpW-1:0]  sp_q, sp_d;
  logic            ok_q, ok_d;
  in_item_t        item_q;
  out_item_t       out_q, res;
  logic            out_valid_q, out_valid_d;
  logic            res_load;
  logic            out_free;
  logic            in_acc;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  stk_entry_t      wr_data;
  logic [AW-1:0]   rd_addr;
  stk_entry_t      top;

  logic [SpW-1:0]  sp_dec;
  logic [1:0]      tok_kind;
  logic            tok_plain;
  logic            tok_opener;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Token decode
  assign sp_dec     = sp_q - SpW'(1);
  assign tok_plain  = (item_q.token_class == TC_PLAIN) || (item_q.token_class == TC_UNUSED);
  assign tok_opener = item_q.token_class[0];
  assign tok_kind   = 2'((item_q.token_class - 3'd1) >> 1);

  // Stack RAM: read top of stack every cycle, push at sp
  assign rd_addr = (sp_q == '0) ? '0 : sp_dec[AW-1:0];
  assign wr_addr = sp_q[AW-1:0];
  assign wr_data = '{kind: tok_kind, index: item_q.token_index};

  bnc_stack_mem #(
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (top)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = (item_q.cmd == CMD_END && sp_q > SpW'(1)) ? ST_DRAIN_RD : ST_IDLE;
        end
      end
      ST_DRAIN_RD: begin
        state_d = ST_DRAIN_EMIT;
      end
      ST_DRAIN_EMIT: begin
        if (out_free) state_d = (sp_q > SpW'(1)) ? ST_DRAIN_RD : ST_IDLE;
      end
    endcase
  end

  // Result, stack update and flag update
  always_comb begin
    sp_d     = sp_q;
    ok_d     = ok_q;
    wr_en    = 1'b0;
    res_load = 1'b0;
    res      = '{event_res:    EV_PLAIN,
                 bracket_kind: KIND_NONE,
                 open_index:   '0,
                 close_index:  item_q.token_index,
                 depth:        DepthW'(sp_q),
                 all_ok:       ok_q,
                 last:         1'b1};
    unique case (state_q)
      ST_EXEC: begin
        if (out_free) begin
          res_load = 1'b1;
          if (item_q.cmd == CMD_END) begin
            if (sp_q == '0) begin
              res.event_res = EV_BALANCED;
              ok_d          = 1'b1;
            end else begin
              // first dangling opener, straight from the top read
              res.event_res    = EV_DANGLE;
              res.bracket_kind = top.kind;
              res.open_index   = top.index;
              res.depth        = DepthW'(sp_dec);
              res.all_ok       = 1'b0;
              res.last         = (sp_dec == '0);
              sp_d             = sp_dec;
              if (sp_dec == '0) ok_d = 1'b1;
            end
          end else if (tok_plain) begin
            res.event_res = EV_PLAIN;
          end else if (tok_opener) begin
            res.bracket_kind = tok_kind;
            res.open_index   = item_q.token_index;
            if (sp_q < SpW'(STACK_DEPTH)) begin
              wr_en         = 1'b1;
              sp_d          = sp_q + SpW'(1);
              res.event_res = EV_OPEN;
              res.depth     = DepthW'(sp_d);
            end else begin
              ok_d          = 1'b0;
              res.event_res = EV_OVERFLOW;
              res.all_ok    = 1'b0;
            end
          end else begin
            res.bracket_kind = tok_kind;
            if (sp_q != '0 && top.kind == tok_kind) begin
              sp_d           = sp_dec;
              res.event_res  = EV_MATCH;
              res.open_index = top.index;
              res.depth      = DepthW'(sp_dec);
            end else begin
              ok_d           = 1'b0;
              res.event_res  = EV_MISMATCH;
              res.open_index = (sp_q != '0) ? top.index : '0;
              res.all_ok     = 1'b0;
            end
          end
        end
      end
      ST_DRAIN_EMIT: begin
        if (out_free) begin
          res_load         = 1'b1;
          res.event_res    = EV_DANGLE;
          res.bracket_kind = top.kind;
          res.open_index   = top.index;
          res.depth        = DepthW'(sp_dec);
          res.all_ok       = 1'b0;
          res.last         = (sp_dec == '0);
          sp_d             = sp_dec;
          if (sp_dec == '0) ok_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_item_i;
    if (res_load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Stack depth never exceeds its capacity
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(STACK_DEPTH))
    else $error("stack pointer beyond capacity");

  // Drain states only run with entries left on the stack
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN_RD || state_q == ST_DRAIN_EMIT) |-> sp_q != '0)
    else $error("drain with empty stack");

  // Final dangling result leaves an empty stack and a fresh ok flag
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && res.event_res == EV_DANGLE && res.last |=> sp_q == '0 && ok_q)
    else $error("drain did not restore stream state");

  // Dangling results always report an error
  a_dangle_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.event_res == EV_DANGLE |-> !out_q.all_ok)
    else $error("dangling result marked ok");

  // A push only happens below capacity
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> sp_q < SpW'(STACK_DEPTH))
    else $error("push into full stack");

endmodule

`default_nettype wire

[tb/bnc_tb_pkg.sv]
// ----------------------------------------------------------------------------
// Bracket checker verification package
// Token-class and kind names plus the scoreboard that predicts the checker's
// events from the token stream and compares them with what the core emits.
// ----------------------------------------------------------------------------
`default_nettype none

package bnc_tb_pkg;

  import bnc_pkg::*;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned MaxReports = 40;

  // Token classes beyond the ones the core package names
  localparam logic [2:0] TC_PAR_OPEN  = 3'd1;
  localparam logic [2:0] TC_PAR_CLOSE = 3'd2;
  localparam logic [2:0] TC_BRK_OPEN  = 3'd3;
  localparam logic [2:0] TC_BRK_CLOSE = 3'd4;
  localparam logic [2:0] TC_BRC_OPEN  = 3'd5;
  localparam logic [2:0] TC_BRC_CLOSE = 3'd6;

  // Bracket kinds
  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_BRACE  = 2'd2;

  // Opener and closer class for each kind
  localparam logic [2:0] OPEN_CLS [3]  = '{TC_PAR_OPEN, TC_BRK_OPEN, TC_BRC_OPEN};
  localparam logic [2:0] CLOSE_CLS [3] = '{TC_PAR_CLOSE, TC_BRK_CLOSE, TC_BRC_CLOSE};

  class bracket_scoreboard;

    stk_entry_t  open_brackets [StackDepth];
    int unsigned nest_depth;
    logic        stream_ok;
    out_item_t   events_due [$];
    int unsigned mismatches;
    longint      stamp;

    function new();
      nest_depth  = 0;
      stream_ok   = 1'b1;
      mismatches  = 0;
      stamp       = 0;
    endfunction

    function int unsigned pending();
      return events_due.size();
    endfunction

    function void post_event(event_e ev, logic [1:0] kind, logic [IdxW-1:0] oidx,
                             logic [IdxW-1:0] cidx, int unsigned dep, logic okv,
                             logic lastv);
      out_item_t r;
      r.event_res    = ev;
      r.bracket_kind = kind;
      r.open_index   = oidx;
      r.close_index  = cidx;
      r.depth        = DepthW'(dep);
      r.all_ok       = okv;
      r.last         = lastv;
      events_due.push_back(r);
    endfunction

    // Work out the events caused by one accepted item
    function void note_token(in_item_t it);
      stk_entry_t e;
      logic [1:0] kind;
      logic       opener;
      logic       bracket;
      bracket = 1'b1;
      opener  = 1'b0;
      kind    = KIND_NONE;
      case (it.token_class)
        TC_PAR_OPEN:  begin kind = KIND_PAREN;  opener = 1'b1; end
        TC_PAR_CLOSE: kind = KIND_PAREN;
        TC_BRK_OPEN:  begin kind = KIND_SQUARE; opener = 1'b1; end
        TC_BRK_CLOSE: kind = KIND_SQUARE;
        TC_BRC_OPEN:  begin kind = KIND_BRACE;  opener = 1'b1; end
        TC_BRC_CLOSE: kind = KIND_BRACE;
        default:      bracket = 1'b0;
      endcase

      if (it.cmd == CMD_END) begin
        // end of stream: balanced, or drain every opener from the top down
        if (nest_depth == 0) begin
          post_event(EV_BALANCED, KIND_NONE, '0, it.token_index, 0, stream_ok, 1'b1);
        end else begin
          while (nest_depth > 0) begin
            nest_depth--;
            e = open_brackets[nest_depth];
            post_event(EV_DANGLE, e.kind, e.index, it.token_index, nest_depth, 1'b0,
                       nest_depth == 0);
          end
        end
        nest_depth = 0;
        stream_ok  = 1'b1;
      end else if (!bracket) begin
        post_event(EV_PLAIN, KIND_NONE, '0, it.token_index, nest_depth, stream_ok, 1'b1);
      end else if (opener) begin
        if (nest_depth < StackDepth) begin
          open_brackets[nest_depth].kind  = kind;
          open_brackets[nest_depth].index = it.token_index;
          nest_depth++;
          post_event(EV_OPEN, kind, it.token_index, it.token_index, nest_depth,
                     stream_ok, 1'b1);
        end else begin
          stream_ok = 1'b0;
          post_event(EV_OVERFLOW, kind, it.token_index, it.token_index, nest_depth,
                     stream_ok, 1'b1);
        end
      end else if (nest_depth > 0 && open_brackets[nest_depth-1].kind == kind) begin
        nest_depth--;
        post_event(EV_MATCH, kind, open_brackets[nest_depth].index, it.token_index,
                   nest_depth, stream_ok, 1'b1);
      end else begin
        // wrong closer: stack left alone, top opener reported if any
        stream_ok = 1'b0;
        post_event(EV_MISMATCH, kind,
                   nest_depth > 0 ? open_brackets[nest_depth-1].index : '0,
                   it.token_index, nest_depth, stream_ok, 1'b1);
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0d ns: %s mismatch, expected %0d, got %0d", stamp, name, want, got);
      end
    endfunction

    // Compare one emitted result with the oldest expected event
    function void check_result(out_item_t act, longint now);
      out_item_t exp;
      stamp = now;
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0d ns: unexpected result, expected none, got %p", stamp, act);
        return;
      end
      exp = events_due.pop_front();
      check_field("event_res", 32'(exp.event_res), 32'(act.event_res));
      check_field("bracket_kind", 32'(exp.bracket_kind), 32'(act.bracket_kind));
      check_field("open_index", 32'(exp.open_index), 32'(act.open_index));
      check_field("close_index", 32'(exp.close_index), 32'(act.close_index));
      check_field("depth", 32'(exp.depth), 32'(act.depth));
      check_field("all_ok", 32'(exp.all_ok), 32'(act.all_ok));
      check_field("last", 32'(exp.last), 32'(act.last));
    endfunction

  endclass

endpackage

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Bracket nesting checker core testbench
// Drives directed token streams and then random streams (well nested, broken,
// stack-filling and noise) with bursty input and a stalling receiver, and
// checks every result against a scoreboard that tracks the bracket stack.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bnc_pkg::*;
  import bnc_tb_pkg::*;

  localparam int unsigned NumItems   = 470;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned TailCycles = 20;

  typedef enum {STREAM_WELL, STREAM_BROKEN, STREAM_FULL, STREAM_NOISE} stream_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  bracket_scoreboard sb;
  int unsigned       items_sent = 0;
  int unsigned       burst_left = 0;
  logic [IdxW-1:0]   tok_idx    = '0;
  bit                hold_req   = 1'b0;
  int unsigned       quiet_cnt  = 0;

  always #5 clk = ~clk;

  bracket_nesting_checker_core #(
    .STACK_DEPTH (StackDepth)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // Monitors: note accepted tokens, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_token(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item, $time);
  end

  // Watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cnt <= 0;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
      if (quiet_cnt >= IdleLimit) begin
        $display("%0d ns: no progress for %0d cycles", $time, IdleLimit);
        $display("bracket_nesting_checker_core regression: fail");
        $finish;
      end
    end
  end

  // Receiver: segments of different stall patterns, plus one long hold-off
  initial begin
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    int unsigned period;
    int unsigned cyc;
    logic        nxt;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    period    = 2;
    cyc       = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_left > 0) begin
        nxt = 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles - 1;
        nxt       = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
          period   = $urandom_range(2, 4);
        end
        seg_left--;
        case (mode)
          0:       nxt = 1'b0;
          1:       nxt = ($urandom_range(0, 1) == 0);
          2:       nxt = (cyc % period == 0);
          default: nxt = ($urandom_range(0, 9) < 8);
        endcase
      end
      out_stall <= nxt;
    end
  end

  function automatic logic [IdxW-1:0] next_index();
    if ($urandom_range(0, 3) == 0) tok_idx = IdxW'($urandom);
    else tok_idx = tok_idx + IdxW'(1);
    return tok_idx;
  endfunction

  // Offer one item, with bursts and gaps, and wait until it is taken
  task automatic send_token(logic cmd, logic [2:0] cls, logic [IdxW-1:0] idx);
    in_item_t    it;
    int unsigned gap;
    it.cmd         = cmd;
    it.token_class = cls;
    it.token_index = idx;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    burst_left--;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering until every expected result has come out
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // One stream of tokens closed by end of stream
  task automatic run_stream(stream_e flavor, int unsigned cap, int unsigned n_tok,
                            bit close_all);
    logic [1:0]  open_kinds [$];
    logic [1:0]  k;
    logic [2:0]  cls;
    int unsigned r;
    int unsigned open_pct;
    int unsigned n_close;
    open_pct = (flavor == STREAM_FULL) ? 90 : 50;
    repeat (n_tok) begin
      r = $urandom_range(0, 99);
      if (flavor == STREAM_NOISE) begin
        cls = 3'($urandom_range(0, 7));
      end else if (r < 8) begin
        cls = (r < 4) ? TC_PLAIN : TC_UNUSED;
      end else if (open_kinds.size() < cap && (open_kinds.size() == 0 || r < open_pct)) begin
        k   = 2'($urandom_range(0, 2));
        cls = OPEN_CLS[k];
        // an opener on a full stack overflows and is not pushed
        if (open_kinds.size() < StackDepth) open_kinds.push_back(k);
      end else if (flavor == STREAM_BROKEN && $urandom_range(0, 5) == 0) begin
        k   = 2'($urandom_range(0, 2));
        cls = CLOSE_CLS[k];
        if (open_kinds.size() > 0 && open_kinds[$] == k) void'(open_kinds.pop_back());
      end else begin
        k   = open_kinds.pop_back();
        cls = CLOSE_CLS[k];
      end
      send_token(CMD_TOKEN, cls, next_index());
    end
    n_close = close_all ? open_kinds.size() : $urandom_range(0, open_kinds.size());
    repeat (n_close) begin
      k = open_kinds.pop_back();
      send_token(CMD_TOKEN, CLOSE_CLS[k], next_index());
    end
    send_token(CMD_END, 3'($urandom_range(0, 7)), next_index());
  endtask

  // Stimulus
  initial begin
    int unsigned stream_no;
    int unsigned r;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain tokens, unused class, balanced end
    send_token(CMD_TOKEN, TC_PLAIN, 16'h0000);
    send_token(CMD_TOKEN, TC_UNUSED, 16'hFFFF);
    send_token(CMD_END, TC_PLAIN, 16'h0002);
    // each kind opened and closed in order
    send_token(CMD_TOKEN, TC_PAR_OPEN, 16'h0010);
    send_token(CMD_TOKEN, TC_BRK_OPEN, 16'h0011);
    send_token(CMD_TOKEN, TC_BRC_OPEN, 16'h0012);
    send_token(CMD_TOKEN, TC_BRC_CLOSE, 16'h0013);
    send_token(CMD_TOKEN, TC_BRK_CLOSE, 16'h0014);
    send_token(CMD_TOKEN, TC_PAR_CLOSE, 16'h0015);
    send_token(CMD_END, TC_UNUSED, 16'h0016);
    // closer on empty stack, then end reports the error
    send_token(CMD_TOKEN, TC_PAR_CLOSE, 16'h0020);
    send_token(CMD_END, TC_PLAIN, 16'h0021);
    // wrong closer under an opener, then dangling openers at end
    send_token(CMD_TOKEN, TC_PAR_OPEN, 16'hFFFF);
    send_token(CMD_TOKEN, TC_BRK_CLOSE, 16'h8000);
    send_token(CMD_TOKEN, TC_BRK_OPEN, 16'h7FFF);
    send_token(CMD_TOKEN, TC_BRC_OPEN, 16'h1234);
    send_token(CMD_TOKEN, TC_BRC_CLOSE, 16'h0001);
    send_token(CMD_END, TC_BRC_OPEN, 16'h5555);
    // mismatch then match, end balanced with error seen
    send_token(CMD_TOKEN, TC_BRK_OPEN, 16'hAAAA);
    send_token(CMD_TOKEN, TC_PAR_CLOSE, 16'h5554);
    send_token(CMD_TOKEN, TC_BRK_CLOSE, 16'h5553);
    send_token(CMD_END, TC_PLAIN, 16'h0000);
    wait_drained();

    // stack filled to overflow, once with a random number of openers left dangling and once closed
    run_stream(STREAM_FULL, StackDepth + 1, 45, 1'b0);
    wait_drained();
    run_stream(STREAM_FULL, StackDepth + 1, 40, 1'b1);

    stream_no = 0;
    while (items_sent < NumItems) begin
      stream_no++;
      r = $urandom_range(0, 99);
      if (stream_no == 4) begin
        // long receiver hold-off while input keeps coming
        hold_req   = 1'b1;
        burst_left = 60;
        run_stream(STREAM_WELL, 8, 30, 1'b1);
      end else if (r < 5) begin
        run_stream(STREAM_FULL, StackDepth + 1, 40, 1'($urandom_range(0, 1)));
      end else if (r < 55) begin
        run_stream(STREAM_WELL, $urandom_range(1, 8), $urandom_range(4, 24), 1'b1);
      end else if (r < 85) begin
        run_stream(STREAM_BROKEN, $urandom_range(1, 8), $urandom_range(4, 24), 1'b0);
      end else begin
        run_stream(STREAM_NOISE, 0, $urandom_range(3, 12), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bracket_nesting_checker_core regression: pass");
    end else begin
      if (sb.pending() != 0)
        $display("%0d ns: %0d expected results never came", $time, sb.pending());
      $display("bracket_nesting_checker_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
sv/bnc_pkg.sv
sv/bnc_stack_mem.sv
sv/bracket_nesting_checker_core.sv
tb/bnc_tb_pkg.sv
tb/tb.sv
